[src/scpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpt_pkg
// Shared opcodes, status codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package scpt_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic [15:0] NO_STEP = 16'hFFFF;

    typedef struct packed {
        logic take;        // latch input transfer
        logic exec;        // run clear/append, arm query
        logic div_step;    // one restoring divide step
        logic col_init;    // load first column, start scan
        logic col_next;    // step one column down, start scan
        logic scan_issue;  // issue one boundary read
    } scpt_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic div_last;
        logic rd_end;
        logic pipe_empty;
        logic col_zero;
        logic hit;
    } scpt_stat_t;

endpackage

[src/scpt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpt_ctrl
// Sequencer: accept, execute, divide, scan columns, deliver result.
// ----------------------------------------------------------------------------
module scpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              out_free,
    input  scpt_pkg::scpt_stat_t st,
    output scpt_pkg::scpt_cmd_t  cmd,
    output logic              in_ready,
    output logic              out_load
);
    import scpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV, S_SETUP, S_SCAN, S_COL_END, S_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.take = in_valid;
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = st.need_scan ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) state_next = S_SETUP;
            end
            S_SETUP: begin
                cmd.col_init = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = !st.rd_end;
                if (st.rd_end && st.pipe_empty) state_next = S_COL_END;
            end
            S_COL_END: begin
                if (st.hit || st.col_zero) begin
                    state_next = S_RESULT;
                end else begin
                    cmd.col_next = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_RESULT: begin
                out_load = out_free;
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/scpt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scpt_dp
// Boundary store, column divider, segment read window and crossing counter.
// ----------------------------------------------------------------------------
module scpt_dp #(
    parameter int MAX_POINTS = 256,
    parameter int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  scpt_pkg::scpt_cmd_t cmd,
    input  logic [1:0]          in_op,
    input  logic signed [15:0]  in_x,
    input  logic signed [15:0]  in_y,
    input  logic [9:0]          tol,
    output scpt_pkg::scpt_stat_t st,
    output logic [CW-1:0]       count,
    output logic                res_inside,
    output logic [15:0]         res_cross,
    output logic [1:0]          res_status
);
    import scpt_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int RW = $clog2(MAX_POINTS + 3);

    logic [31:0]        mem [MAX_POINTS];
    logic [31:0]        rdata_reg;

    logic [1:0]         op_reg;
    logic signed [15:0] qx_reg, qy_reg;
    logic [CW-1:0]      count_reg;
    logic signed [15:0] last_x_reg;
    logic [15:0]        min_step_reg;
    logic [1:0]         status_reg;
    logic [15:0]        cross_reg;
    logic               hit_reg;

    logic [14:0]        dvd_reg, quo_reg, col_reg, cx_reg;
    logic [15:0]        rem_reg;
    logic [3:0]         div_cnt_reg;

    logic [RW-1:0]      rd_idx_reg;
    logic               v1_reg, real1_reg, v2_reg;
    logic signed [15:0] w_x_reg [4];
    logic signed [15:0] w_y_reg [4];
    logic [3:0]         w_real_reg;

    logic               full, rd_real;
    logic signed [16:0] step_d;
    logic [16:0]        rem_sh;
    logic               q_bit;
    logic [14:0]        qxm1;
    logic [15:0]        cx_dec;

    assign full   = !(count_reg < CW'(MAX_POINTS));
    assign step_d = 17'(qx_reg) - 17'(last_x_reg);
    assign rd_real = rd_idx_reg < RW'(count_reg);
    assign qxm1   = 15'(qx_reg[14:0] - 15'd1);
    assign rem_sh = {rem_reg, dvd_reg[14]};
    assign q_bit  = rem_sh >= {1'b0, min_step_reg};
    assign cx_dec = {1'b0, cx_reg} - min_step_reg;

    // segment evaluation on the read window
    logic signed [17:0] dxa, dxb, tol_s;
    logic signed [16:0] da, db, g12, g34, exa, exb;
    logic               in_col, ev_zero, ev_neg, corner, horiz, eval;
    logic [1:0]         inc;
    logic [16:0]        cross_sum;

    always_comb begin
        tol_s   = 18'(tol);
        dxa     = 18'(cx_reg) - 18'(w_x_reg[0]);
        dxb     = 18'(cx_reg) - 18'(w_x_reg[1]);
        in_col  = (dxa <= tol_s) && (dxa >= -tol_s) && (dxb <= tol_s) && (dxb >= -tol_s);
        da      = 17'(w_y_reg[0]) - 17'(qy_reg);
        db      = 17'(w_y_reg[1]) - 17'(qy_reg);
        ev_zero = (da == '0) || (db == '0);
        ev_neg  = !ev_zero && (da[16] ^ db[16]);
        g12     = 17'(w_y_reg[0]) - 17'(w_y_reg[1]);
        g34     = 17'(w_y_reg[2]) - 17'(w_y_reg[3]);
        corner  = w_real_reg[3] && ev_zero && (w_y_reg[1] == w_y_reg[2]) &&
                  (g12 != '0) && (g34 != '0) && (g12[16] == g34[16]);
        exa     = 17'(w_x_reg[0]) - 17'(qx_reg);
        exb     = 17'(w_x_reg[1]) - 17'(qx_reg);
        horiz   = !in_col && (w_y_reg[0] == w_y_reg[1]) && (qy_reg == w_y_reg[0]) &&
                  (exa != '0) && (exb != '0) && (exa[16] ^ exb[16]);
        eval    = v2_reg && !hit_reg && w_real_reg[0] && w_real_reg[1];
        inc     = (in_col && (ev_zero || ev_neg)) ? (corner ? 2'd2 : 2'd1) : 2'd0;
        cross_sum = {1'b0, cross_reg} + 17'(inc);
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && op_reg == OP_APPEND && !full) begin
            mem[count_reg[AW-1:0]] <= {qy_reg, qx_reg};
        end
        rdata_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            min_step_reg <= NO_STEP;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            w_real_reg   <= '0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.take) begin
                op_reg <= in_op;
                qx_reg <= in_x;
                qy_reg <= in_y;
            end
            if (cmd.exec) begin
                cross_reg   <= '0;
                hit_reg     <= 1'b0;
                dvd_reg     <= qxm1;
                rem_reg     <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= '0;
                status_reg  <= ST_OK;
                unique case (op_reg)
                    OP_CLEAR: begin
                        count_reg    <= '0;
                        min_step_reg <= NO_STEP;
                    end
                    OP_APPEND: begin
                        if (full) begin
                            status_reg <= ST_FULL;
                        end else begin
                            if (count_reg != '0 && !step_d[16] && step_d != '0 &&
                                step_d[15:0] < min_step_reg) begin
                                min_step_reg <= step_d[15:0];
                            end
                            last_x_reg <= qx_reg;
                            count_reg  <= count_reg + CW'(1);
                        end
                    end
                    OP_QUERY: begin
                        if (count_reg < CW'(2)) status_reg <= ST_SHORT;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_step) begin
                rem_reg     <= q_bit ? 16'(rem_sh - {1'b0, min_step_reg}) : rem_sh[15:0];
                quo_reg     <= {quo_reg[13:0], q_bit};
                dvd_reg     <= {dvd_reg[13:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (cmd.col_init) begin
                col_reg <= quo_reg;
                cx_reg  <= 15'(qxm1 - rem_reg[14:0]);
            end
            if (cmd.col_next) begin
                col_reg <= col_reg - 15'd1;
                cx_reg  <= cx_dec[14:0];
            end
            // read pipeline: issue, registered data, window shift, evaluate
            if (cmd.col_init || cmd.col_next) begin
                rd_idx_reg <= '0;
                w_real_reg <= '0;
                v1_reg     <= 1'b0;
                v2_reg     <= 1'b0;
            end else begin
                if (cmd.scan_issue) rd_idx_reg <= rd_idx_reg + RW'(1);
                v1_reg    <= cmd.scan_issue;
                real1_reg <= cmd.scan_issue && rd_real;
                v2_reg    <= v1_reg;
                if (v1_reg) begin
                    for (int k = 0; k < 3; k++) begin
                        w_x_reg[k] <= w_x_reg[k+1];
                        w_y_reg[k] <= w_y_reg[k+1];
                    end
                    w_x_reg[3] <= rdata_reg[15:0];
                    w_y_reg[3] <= rdata_reg[31:16];
                    w_real_reg <= {real1_reg, w_real_reg[3:1]};
                end
            end
            if (eval) begin
                if (in_col) begin
                    cross_reg <= cross_sum[16] ? 16'hFFFF : cross_sum[15:0];
                end else if (horiz) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    assign st.need_scan  = (op_reg == OP_QUERY) && !(count_reg < CW'(2)) &&
                           !qx_reg[15] && (qx_reg != '0);
    assign st.div_last   = (div_cnt_reg == 4'd14);
    assign st.rd_end     = !(rd_idx_reg < (RW'(count_reg) + RW'(2)));
    assign st.pipe_empty = !v1_reg && !v2_reg;
    assign st.col_zero   = (col_reg == '0);
    assign st.hit        = hit_reg;

    assign count      = count_reg;
    assign res_inside = hit_reg | cross_reg[0];
    assign res_cross  = cross_reg;
    assign res_status = status_reg;

endmodule

[src/staircase_contour_point_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staircase_contour_point_test
// Staircase boundary store with ray-cast point-in-contour query.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tuser: opcode; tdata: coord_x, coord_y
// m_        out  m_tvalid/m_tready  tuser: status; tdata: inside_res, crossings
// cfg_      in   cfg_we             cfg_wdata: x_tolerance
//
// Clear, append and short queries go from execute straight to the result.
// A scanning query walks up to cols columns over N stored points,
// cols = ceil(coord_x / min_step): one boundary memory read per cycle per column,
// after a 15-step restoring divide that finds the first column.
// One item is in work at a time; the finished result waits in the output
// register, and a stalled m_ side holds the block before its next transfer.
// Reset (aresetn low, synchronous) empties the boundary and restores tolerance 16.
// ----------------------------------------------------------------------------
module staircase_contour_point_test #(
    parameter int MAX_POINTS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] coord_x, [31:16] coord_y
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] inside_res, [16:1] crossings, zero pad
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);
    import scpt_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    scpt_cmd_t     cmd;
    scpt_stat_t    st;
    logic [CW-1:0] count;
    logic          out_load, out_free;
    logic          res_inside;
    logic [15:0]   res_cross;
    logic [1:0]    res_status;

    logic [9:0]    tol_reg;
    logic          m_tvalid_reg;
    logic          inside_reg;
    logic [15:0]   cross_out_reg;
    logic [1:0]    status_out_reg;

    // Hold the tolerance; the user must write it only while idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 10'd16;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // Output slot frees when empty or drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    scpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd),
        .in_ready (s_tready),
        .out_load (out_load)
    );

    scpt_dp #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_op      (s_tuser),
        .in_x       (s_tdata[15:0]),
        .in_y       (s_tdata[31:16]),
        .tol        (tol_reg),
        .st         (st),
        .count      (count),
        .res_inside (res_inside),
        .res_cross  (res_cross),
        .res_status (res_status)
    );

    // Output register: load on result, drop valid after transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            inside_reg     <= res_inside;
            cross_out_reg  <= res_cross;
            status_out_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, cross_out_reg, inside_reg};
    assign m_tuser  = status_out_reg;

    // An error result carries no crossings and no inside flag.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_SHORT) |-> m_tdata == '0)
        else $error("error result with nonzero payload");

    // Outside implies an even crossing count.
    a_outside_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> !m_tdata[1])
        else $error("outside result with odd crossings");

    // The boundary never grows past its capacity.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    // A scan in progress never accepts a new item.
    a_busy_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !st.pipe_empty |-> !s_tready)
        else $error("input ready during scan");

endmodule
